FILE: rtl/mfpc_pkg.sv
// ----------------------------------------------------------------------------
// mfpc_pkg
// Shared widths, constants and codes of the motor fader position controller.
// ----------------------------------------------------------------------------
package mfpc_pkg;

  // field widths
  localparam int MODE_W     = 2;
  localparam int TGT_W      = 16;
  localparam int POS_W      = 12;
  localparam int PER_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // averaging window, depth is a power of two
  localparam int SAMPLE_BITS = 12;
  localparam int WIN_LG      = 3;
  localparam int WINDOW      = 1 << WIN_LG;
  localparam int SLOT_W      = WIN_LG;
  localparam int SUM_W       = SAMPLE_BITS + WIN_LG;

  // duty arithmetic
  localparam int SQ_W     = 2 * POS_W;
  localparam int MUL_A_W  = 26;
  localparam int MUL_B_W  = 25;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int DUTY_DIV = 20000;

  localparam logic [PROD_W-1:0]  DIV_LIMIT  = PROD_W'(DUTY_DIV) << PER_W;
  localparam logic [MUL_B_W-1:0] RECIP5     = MUL_B_W'(52429);
  localparam int                 RECIP5_SH  = 18;
  localparam logic [PER_W-1:0]   DUTY_FLOOR = PER_W'(300);

  // duty scale is 625 << 5: shift first, then multiply by ceil(2^34 / 625)
  localparam int                 DIV_PRE_SH = 5;
  localparam logic [MUL_B_W-1:0] RECIP625   = MUL_B_W'(27487791);
  localparam int                 RECIP_SH   = 34;

  // reset values of the registers
  localparam logic [POS_W-1:0] TOL_RST    = POS_W'(10);
  localparam logic [POS_W-1:0] MIN_RST    = POS_W'(0);
  localparam logic [POS_W-1:0] MAX_RST    = POS_W'(4095);
  localparam logic [PER_W-1:0] PERIOD_RST = PER_W'(20000);

  typedef enum logic [MODE_W-1:0] {
    MODE_SET    = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_EVAL   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOL    = 2'd0,
    CFG_MIN    = 2'd1,
    CFG_MAX    = 2'd2,
    CFG_PERIOD = 2'd3
  } cfg_idx_e;

  // request into the duty unit
  typedef struct packed {
    logic             start;
    logic [POS_W-1:0] delta;
    logic [PER_W-1:0] period;
  } duty_req_t;

  // answer from the duty unit
  typedef struct packed {
    logic             done;
    logic [PER_W-1:0] duty;
  } duty_rsp_t;

endpackage

FILE: rtl/mfpc_if.sv
// ----------------------------------------------------------------------------
// mfpc_if
// Valid/ready channels of the fader controller: input items and results.
// ----------------------------------------------------------------------------
interface mfpc_in_if;
  logic                             valid;
  logic                             ready;
  logic [mfpc_pkg::MODE_W-1:0]      mode;
  logic [mfpc_pkg::TGT_W-1:0]       new_target;
  logic [mfpc_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output mode, output new_target, output sample, input ready);
  modport sink   (input valid, input mode, input new_target, input sample, output ready);
endinterface

interface mfpc_out_if;
  logic                       valid;
  logic                       ready;
  logic [mfpc_pkg::POS_W-1:0] average;
  logic                       touched;
  logic [mfpc_pkg::PER_W-1:0] drive_forward;
  logic [mfpc_pkg::PER_W-1:0] drive_backward;
  logic                       moving_now;

  modport source (output valid, output average, output touched, output drive_forward,
                  output drive_backward, output moving_now, input ready);
  modport sink   (input valid, input average, input touched, input drive_forward,
                  input drive_backward, input moving_now, output ready);
endinterface

FILE: rtl/mfpc_window.sv
// ----------------------------------------------------------------------------
// mfpc_window
// Moving-average window: ring of samples with a running sum.
// ----------------------------------------------------------------------------
module mfpc_window (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [mfpc_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic [mfpc_pkg::SUM_W-1:0]       sum_o
);

  logic [mfpc_pkg::SAMPLE_BITS-1:0] win_q [mfpc_pkg::WINDOW];
  logic [mfpc_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic [mfpc_pkg::SUM_W-1:0]       sum_q, sum_d;

  always_comb begin
    sum_d  = sum_q - mfpc_pkg::SUM_W'(win_q[slot_q]) + mfpc_pkg::SUM_W'(sample_i);
    slot_d = (slot_q == mfpc_pkg::SLOT_W'(mfpc_pkg::WINDOW - 1)) ? '0 : slot_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mfpc_pkg::WINDOW; i++) win_q[i] <= '0;
      slot_q <= '0;
      sum_q  <= '0;
    end else if (push_i) begin
      win_q[slot_q] <= sample_i;
      slot_q        <= slot_d;
      sum_q         <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

FILE: rtl/mfpc_duty.sv
// ----------------------------------------------------------------------------
// mfpc_duty
// Motor duty from distance and period on one shared multiplier; the divide
// by the duty scale is a reciprocal multiply on the same unit.
// ----------------------------------------------------------------------------
module mfpc_duty (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mfpc_pkg::duty_req_t req_i,
  output mfpc_pkg::duty_rsp_t rsp_o
);

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_P5   = 6'b000010,
    D_SQ   = 6'b000100,
    D_MP   = 6'b001000,
    D_DIV  = 6'b010000,
    D_FIN  = 6'b100000
  } dstate_e;

  dstate_e                          state_q, state_d;
  logic [mfpc_pkg::POS_W-1:0]       dist_q;
  logic [mfpc_pkg::PER_W-1:0]       period_q;
  logic [mfpc_pkg::PER_W-1:0]       p5_q;
  logic [mfpc_pkg::PROD_W-1:0]      prod_q;
  logic                             over_q;
  logic [mfpc_pkg::PER_W-1:0]       quo_q;

  logic [mfpc_pkg::MUL_A_W-1:0]     mul_a;
  logic [mfpc_pkg::MUL_B_W-1:0]     mul_b;
  logic [mfpc_pkg::PROD_W-1:0]      mul_p;
  logic [mfpc_pkg::PER_W-1:0]       capped;
  logic [mfpc_pkg::PER_W-1:0]       duty;

  // shared multiplier operand select
  always_comb begin
    unique case (state_q)
      D_P5: begin
        mul_a = mfpc_pkg::MUL_A_W'(period_q);
        mul_b = mfpc_pkg::RECIP5;
      end
      D_SQ: begin
        mul_a = mfpc_pkg::MUL_A_W'(dist_q);
        mul_b = mfpc_pkg::MUL_B_W'(dist_q);
      end
      D_DIV: begin
        // below the limit the shifted product fits the operand width
        mul_a = prod_q[mfpc_pkg::DIV_PRE_SH +: mfpc_pkg::MUL_A_W];
        mul_b = mfpc_pkg::RECIP625;
      end
      default: begin
        mul_a = mfpc_pkg::MUL_A_W'(prod_q[mfpc_pkg::SQ_W-1:0]);
        mul_b = mfpc_pkg::MUL_B_W'(period_q);
      end
    endcase
    mul_p = mfpc_pkg::PROD_W'(mul_a) * mfpc_pkg::PROD_W'(mul_b);
  end

  always_comb begin
    if (over_q || quo_q > period_q) capped = period_q;
    else                            capped = quo_q;
    if (capped > mfpc_pkg::DUTY_FLOOR) duty = (capped < p5_q) ? p5_q : capped;
    else                               duty = '0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      D_IDLE:  if (req_i.start) state_d = D_P5;
      D_P5:    state_d = D_SQ;
      D_SQ:    state_d = D_MP;
      D_MP:    state_d = D_DIV;
      D_DIV:   state_d = D_FIN;
      D_FIN:   state_d = D_IDLE;
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      D_IDLE: begin
        dist_q   <= req_i.delta;
        period_q <= req_i.period;
      end
      D_P5: begin
        prod_q <= mul_p;
      end
      D_SQ: begin
        p5_q   <= prod_q[mfpc_pkg::RECIP5_SH +: mfpc_pkg::PER_W];
        prod_q <= mul_p;
      end
      D_MP: begin
        // at or above the limit the quotient exceeds any period
        prod_q <= mul_p;
        over_q <= mul_p >= mfpc_pkg::DIV_LIMIT;
      end
      D_DIV: begin
        quo_q <= mul_p[mfpc_pkg::RECIP_SH +: mfpc_pkg::PER_W];
      end
      default: begin
        quo_q <= quo_q;
      end
    endcase
  end

  assign rsp_o.done = (state_q == D_FIN);
  assign rsp_o.duty = duty;

endmodule

FILE: rtl/motor_fader_position_controller_unit.sv
// ----------------------------------------------------------------------------
// motor_fader_position_controller_unit
// Drives a motorized fader toward a clamped target from a moving average of
// ADC samples, reporting hand touches while idle.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_if    in   valid / ready    mode, new_target, sample
//  out_if   out  valid / ready    average, touched, drive_forward,
//                                 drive_backward, moving_now
//  cfg      in   cfg_we_i         cfg_idx_i, cfg_wdata_i
//
// set-target, sample-only and ignored items return no result and do not hold the input.
// an idle evaluation passes through EVAL and EMIT; a moving one also waits in DUTY on the duty
// unit: four passes through its multiplier, the last a reciprocal divide.
// reset gives the register reset values, an empty window and an idle fader.
// a full output register holds a finished evaluation, and the input with it.
// ----------------------------------------------------------------------------
module motor_fader_position_controller_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  mfpc_in_if.sink                           in_if,
  mfpc_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [mfpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mfpc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DUTY = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e                      state_q, state_d;
  logic [mfpc_pkg::POS_W-1:0]  tol_q, min_q, max_q;
  logic [mfpc_pkg::PER_W-1:0]  period_q;
  logic [mfpc_pkg::POS_W-1:0]  target_q;
  logic                        moving_q;
  logic [mfpc_pkg::PER_W-1:0]  duty_q;

  logic                        out_vld_q;
  logic [mfpc_pkg::POS_W-1:0]  out_avg_q;
  logic                        out_touch_q;
  logic [mfpc_pkg::PER_W-1:0]  out_fwd_q, out_bwd_q;
  logic                        out_mov_q;

  logic                        in_acc;
  mfpc_pkg::mode_e             mode;
  logic                        push;
  logic [mfpc_pkg::SUM_W-1:0]  sum;
  logic [mfpc_pkg::POS_W-1:0]  avg;
  logic [mfpc_pkg::POS_W-1:0]  delta;
  logic                        far;
  logic                        above;
  logic [mfpc_pkg::POS_W-1:0]  clamped;
  logic                        emit;
  mfpc_pkg::duty_req_t         duty_req;
  mfpc_pkg::duty_rsp_t         duty_rsp;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign mode        = mfpc_pkg::mode_e'(in_if.mode);
  assign push        = in_acc && (mode == mfpc_pkg::MODE_SAMPLE || mode == mfpc_pkg::MODE_EVAL);

  mfpc_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (in_if.sample),
    .sum_o    (sum)
  );

  always_comb begin
    avg   = mfpc_pkg::POS_W'(sum >> mfpc_pkg::WIN_LG);
    above = target_q > avg;
    delta = above ? target_q - avg : avg - target_q;
    far   = delta > tol_q;
  end

  // when the two cross, a target below the minimum takes the minimum and any other the maximum
  always_comb begin
    priority if (in_if.new_target < mfpc_pkg::TGT_W'(min_q)) begin
      clamped = min_q;
    end else if (in_if.new_target > mfpc_pkg::TGT_W'(max_q)) begin
      clamped = max_q;
    end else begin
      clamped = in_if.new_target[mfpc_pkg::POS_W-1:0];
    end
  end

  assign duty_req.start  = (state_q == S_EVAL) && moving_q;
  assign duty_req.delta  = delta;
  assign duty_req.period = period_q;

  mfpc_duty u_duty (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (duty_req),
    .rsp_o  (duty_rsp)
  );

  assign emit = (state_q == S_EMIT) && (!out_vld_q || out_if.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && mode == mfpc_pkg::MODE_EVAL) state_d = S_EVAL;
      S_EVAL:  state_d = moving_q ? S_DUTY : S_EMIT;
      S_DUTY:  if (duty_rsp.done) state_d = S_EMIT;
      S_EMIT:  if (emit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tol_q     <= mfpc_pkg::TOL_RST;
      min_q     <= mfpc_pkg::MIN_RST;
      max_q     <= mfpc_pkg::MAX_RST;
      period_q  <= mfpc_pkg::PERIOD_RST;
      target_q  <= '0;
      moving_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (mfpc_pkg::cfg_idx_e'(cfg_idx_i))
          mfpc_pkg::CFG_TOL:    tol_q    <= cfg_wdata_i[mfpc_pkg::POS_W-1:0];
          mfpc_pkg::CFG_MIN:    min_q    <= cfg_wdata_i[mfpc_pkg::POS_W-1:0];
          mfpc_pkg::CFG_MAX:    max_q    <= cfg_wdata_i[mfpc_pkg::POS_W-1:0];
          mfpc_pkg::CFG_PERIOD: period_q <= cfg_wdata_i[mfpc_pkg::PER_W-1:0];
          default:              tol_q    <= tol_q;
        endcase
      end
      if (in_acc && mode == mfpc_pkg::MODE_SET) begin
        target_q <= clamped;
        moving_q <= 1'b1;
      end
      if (emit) begin
        // idle: a hand move adopts the average; moving: stop inside the band
        if (!moving_q && far) target_q <= avg;
        moving_q  <= moving_q && far;
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DUTY && duty_rsp.done) duty_q <= duty_rsp.duty;
    if (emit) begin
      out_avg_q   <= avg;
      out_touch_q <= !moving_q && far;
      out_fwd_q   <= (moving_q && far && above)  ? duty_q : '0;
      out_bwd_q   <= (moving_q && far && !above) ? duty_q : '0;
      out_mov_q   <= moving_q && far;
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.average        = out_avg_q;
  assign out_if.touched        = out_touch_q;
  assign out_if.drive_forward  = out_fwd_q;
  assign out_if.drive_backward = out_bwd_q;
  assign out_if.moving_now     = out_mov_q;

endmodule

FILE: rtl/mfpc_checker.sv
// ----------------------------------------------------------------------------
// mfpc_prop_checker
// Port-level checks of the fader controller, bound to the top level.
// ----------------------------------------------------------------------------
module mfpc_prop_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [mfpc_pkg::MODE_W-1:0]   in_mode_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [mfpc_pkg::POS_W-1:0]    out_average_i,
  input logic                          out_touched_i,
  input logic [mfpc_pkg::PER_W-1:0]    out_fwd_i,
  input logic [mfpc_pkg::PER_W-1:0]    out_bwd_i,
  input logic                          out_moving_i
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_average_i)
      && $stable(out_fwd_i) && $stable(out_bwd_i) && $stable(out_touched_i))
    else $error("result word changed while stalled");

  a_one_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_fwd_i == '0 || out_bwd_i == '0)
    else $error("both motor directions driven");

  a_stop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_moving_i |-> out_fwd_i == '0 && out_bwd_i == '0)
    else $error("drive while not moving");

  a_touch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_touched_i |-> !out_moving_i)
    else $error("touch reported while moving");

  // items without a result finish in the cycle they are taken
  a_short_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_mode_i != mfpc_pkg::MODE_EVAL |=> in_ready_i)
    else $error("non-evaluate item held the input");

endmodule

bind motor_fader_position_controller_unit mfpc_prop_checker u_mfpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .in_mode_i     (in_if.mode),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_average_i (out_if.average),
  .out_touched_i (out_if.touched),
  .out_fwd_i     (out_if.drive_forward),
  .out_bwd_i     (out_if.drive_backward),
  .out_moving_i  (out_if.moving_now)
);
